FILE: rtl/bni_pkg.sv
`default_nettype none
package bni_pkg;
    localparam int unsigned MaxChannelsDefault = 256;
    localparam int unsigned DataW = 32;
    localparam int unsigned ChanW = 8;
    localparam int unsigned SpatW = 24;
    localparam int unsigned SpatCfgW = 25;
    localparam int unsigned ChCfgW = 9;
    localparam int unsigned SpatialLimit = 25'd16777216;

    localparam logic RegChannelCount = 1'b0;
    localparam logic RegSpatialCount = 1'b1;

    localparam logic ActLoad = 1'b0;
    localparam logic ActSample = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch sample and channel, present table address
        logic root_init; // start square root with variance read data
        logic root_step;
        logic div_init;
        logic div_step;
        logic finish;    // form result into output register
    } t_dp_cmd;

    typedef struct packed {
        logic root_done;
        logic div_done;
    } t_dp_status;
endpackage
`default_nettype wire

FILE: rtl/bni_ram.sv
`default_nettype none
module bni_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/bni_datapath.sv
`default_nettype none
module bni_datapath
    import bni_pkg::*;
#(
    parameter int unsigned MAX_CHANNELS = MaxChannelsDefault
) (
    input  wire logic              i_clk,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_status             o_status,
    input  wire logic              i_load_we,
    input  wire logic [ChanW-1:0]  i_load_idx,
    input  wire logic [DataW-1:0]  i_mean,
    input  wire logic [DataW-1:0]  i_var,
    input  wire logic [DataW-1:0]  i_bias,
    input  wire logic [DataW-1:0]  i_sample,
    input  wire logic [ChanW-1:0]  i_chan,
    output logic      [DataW-1:0]  o_result,
    output logic                   o_sat
);
    localparam int unsigned AddrW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [AddrW-1:0] w_waddr, w_raddr;
    logic             w_we;
    logic [DataW-1:0] w_mean, w_var, w_bias;

    // out-of-range loads are dropped; the channel position never reaches
    // the table depth, so both indexes address the tables directly
    assign w_we    = i_load_we && ({24'd0, i_load_idx} < MAX_CHANNELS);
    assign w_waddr = AddrW'(i_load_idx);
    assign w_raddr = AddrW'(i_chan);

    bni_ram #(.WIDTH(DataW), .DEPTH(MAX_CHANNELS)) u_mean (
        .i_clk, .i_we(w_we), .i_waddr(w_waddr), .i_wdata(i_mean),
        .i_raddr(w_raddr), .o_rdata(w_mean));
    bni_ram #(.WIDTH(DataW), .DEPTH(MAX_CHANNELS)) u_var (
        .i_clk, .i_we(w_we), .i_waddr(w_waddr), .i_wdata(i_var),
        .i_raddr(w_raddr), .o_rdata(w_var));
    bni_ram #(.WIDTH(DataW), .DEPTH(MAX_CHANNELS)) u_bias (
        .i_clk, .i_we(w_we), .i_waddr(w_waddr), .i_wdata(i_bias),
        .i_raddr(w_raddr), .o_rdata(w_bias));

    logic signed [DataW-1:0] r_sample;
    logic signed [DataW:0]   r_diff;
    logic [DataW-1:0]        r_biasq;
    // square root of var<<16: one result bit from two radicand bits per step, 24 steps
    logic [49:0] r_rem;
    logic [23:0] r_root;
    logic [47:0] r_rad;
    logic [4:0]  r_rcnt;
    // restoring divide: 48-bit magnitude by 25-bit denominator, 48 steps
    logic [47:0] r_quo;
    logic [25:0] r_drem;
    logic [24:0] r_den;
    logic [5:0]  r_dcnt;

    logic [49:0] w_trial;
    logic [49:0] w_rsh;
    logic [26:0] w_dsh;
    logic [26:0] w_dsub;
    logic [DataW:0] w_mag;

    assign w_rsh   = {r_rem[47:0], r_rad[47:46]};
    assign w_trial = w_rsh - {24'd0, r_root, 2'b01};
    assign w_dsh   = {r_drem, r_quo[47]};
    assign w_dsub  = w_dsh - {2'b0, r_den};
    assign w_mag   = r_diff[DataW] ? -r_diff : r_diff;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_sample;
        end
        if (i_cmd.root_init) begin
            r_diff  <= {r_sample[DataW-1], r_sample} - {w_mean[DataW-1], w_mean};
            r_biasq <= w_bias;
            r_rad   <= {w_var, 16'd0};
            r_rem   <= '0;
            r_root  <= '0;
            r_rcnt  <= '0;
        end else if (i_cmd.root_step) begin
            r_rad  <= {r_rad[45:0], 2'b00};
            r_rcnt <= r_rcnt + 5'd1;
            if (!w_trial[49]) begin
                r_rem  <= w_trial;
                r_root <= {r_root[22:0], 1'b1};
            end else begin
                r_rem  <= w_rsh;
                r_root <= {r_root[22:0], 1'b0};
            end
        end
        if (i_cmd.div_init) begin
            r_den  <= {1'b0, r_root} + 25'd1;
            r_quo  <= {w_mag[31:0], 16'd0};
            r_drem <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 6'd1;
            if (!w_dsub[26]) begin
                r_drem <= w_dsub[25:0];
                r_quo  <= {r_quo[46:0], 1'b1};
            end else begin
                r_drem <= w_dsh[25:0];
                r_quo  <= {r_quo[46:0], 1'b0};
            end
        end
    end

    // final: sign, clip quotient, add bias, clip sum
    logic               w_neg;
    logic signed [33:0] w_q;
    logic signed [33:0] w_sum;
    logic               w_qsat;
    logic signed [33:0] w_qc;
    always_comb begin
        w_neg  = r_diff[DataW];
        w_qsat = 1'b0;
        if (r_quo[47:32] != 16'd0) begin
            w_qsat = 1'b1;
            w_qc   = w_neg ? -34'sd2147483648 : 34'sd2147483647;
        end else begin
            w_q = {2'b0, r_quo[31:0]};
            if (w_neg) begin
                w_q = -w_q;
            end
            if (w_q > 34'sd2147483647) begin
                w_qsat = 1'b1;
                w_qc   = 34'sd2147483647;
            end else if (w_q < -34'sd2147483648) begin
                w_qsat = 1'b1;
                w_qc   = -34'sd2147483648;
            end else begin
                w_qc = w_q;
            end
        end
        w_q   = '0;
        w_sum = w_qc + {{2{r_biasq[DataW-1]}}, r_biasq};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (w_sum > 34'sd2147483647) begin
                o_result <= 32'h7fffffff;
                o_sat    <= 1'b1;
            end else if (w_sum < -34'sd2147483648) begin
                o_result <= 32'h80000000;
                o_sat    <= 1'b1;
            end else begin
                o_result <= w_sum[31:0];
                o_sat    <= w_qsat;
            end
        end
    end

    assign o_status.root_done = (r_rcnt == 5'd23);
    assign o_status.div_done  = (r_dcnt == 6'd47);
endmodule
`default_nettype wire

FILE: rtl/bni_ctrl.sv
`default_nettype none
module bni_ctrl
    import bni_pkg::*;
#(
    parameter int unsigned MAX_CHANNELS = MaxChannelsDefault
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_idx,
    input  wire logic [SpatCfgW-1:0]  i_cfg_data,
    input  wire logic                 i_in_fire,
    input  wire logic                 i_in_sample,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [ChanW-1:0]          o_chan,
    output logic                      o_last,
    output t_dp_cmd                   o_cmd,
    input  wire t_dp_status           i_status
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_ROOT = 6'b000100,
        S_DIV  = 6'b001000,
        S_FIN  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    localparam int unsigned ChLim = (MAX_CHANNELS < 256) ? MAX_CHANNELS : 256;

    t_state r_state, n_state;
    logic [ChCfgW-1:0]   r_ch_cnt;
    logic [SpatCfgW-1:0] r_sp_cnt;
    logic [ChanW-1:0]    r_ch_pos, n_ch_pos;
    logic [SpatW-1:0]    r_sp_pos, n_sp_pos;
    logic [ChanW-1:0]    r_chan;
    logic                r_last;
    logic [ChCfgW-1:0]   w_nch;
    logic [SpatCfgW-1:0] w_nsp;
    logic                w_last;
    logic                r_cmd_div_started;

    always_comb begin
        w_nch = r_ch_cnt;
        if (w_nch == '0) w_nch = ChCfgW'(1);
        if (w_nch > ChCfgW'(ChLim)) w_nch = ChCfgW'(ChLim);
        w_nsp = r_sp_cnt;
        if (w_nsp == '0) w_nsp = SpatCfgW'(1);
        if (w_nsp > SpatCfgW'(SpatialLimit)) w_nsp = SpatCfgW'(SpatialLimit);
        w_last = ({1'b0, r_sp_pos} + 25'd1) >= w_nsp;
        n_sp_pos = w_last ? '0 : r_sp_pos + 24'd1;
        n_ch_pos = r_ch_pos;
        if (w_last) begin
            n_ch_pos = (({1'b0, r_ch_pos} + 9'd1) >= w_nch) ? '0 : r_ch_pos + 8'd1;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_fire && i_in_sample) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.root_init = 1'b1;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_status.root_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!r_cmd_div_started) begin
                    o_cmd.div_init = 1'b1;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_status.div_done) n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ch_cnt <= ChCfgW'(1);
            r_sp_cnt <= SpatCfgW'(1);
            r_ch_pos <= '0;
            r_sp_pos <= '0;
            r_cmd_div_started <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cmd_div_started <= (r_state == S_DIV);
            if (i_cfg_we) begin
                if (i_cfg_idx == RegChannelCount) r_ch_cnt <= i_cfg_data[ChCfgW-1:0];
                else r_sp_cnt <= i_cfg_data;
            end
            if (o_cmd.capture) begin
                r_ch_pos <= n_ch_pos;
                r_sp_pos <= n_sp_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd.capture) begin
            r_chan <= r_ch_pos;
            r_last <= w_last;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_chan      = (r_state == S_IDLE) ? r_ch_pos : r_chan;
    assign o_last      = r_last;
endmodule
`default_nettype wire

FILE: rtl/batch_norm_inference.sv
`default_nettype none
// Batch-norm inference, signed Q16.16, one channel parameter set per channel.
// Input stream s_axis: tuser = action (0 load, 1 sample). Load beats write
// mean/variance/bias of channel_index into three 32-bit tables; samples are
// normalized as (sample-mean)/(isqrt(var)+1 LSB)+bias with saturation.
// Channel of each sample comes from internal counters (spatial_count samples
// per plane, channel_count planes, then wrap).
// Config channel: i_cfg_valid/o_cfg_ready, index 0 channel_count,
// index 1 spatial_count; write only while idle.
// Timing: a load beat leaves the input ready for the next beat. A sample runs
// a table read, 24 square-root steps, a divide init, 48 divide steps and a
// finish; the result beat is then held valid until its handshake. The next
// beat is taken in the cycle after the result handshake, so the block takes
// no new beat while a sample is in the bit-serial root or the 48-bit divider.
// While the result is stalled, no new beat is taken.
// Reset: synchronous active low; state, config registers and position counters
// to reset values; tables and datapath registers are not cleared.
module batch_norm_inference
    import bni_pkg::*;
#(
    parameter int unsigned MAX_CHANNELS = MaxChannelsDefault
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic         i_cfg_index,
    input  wire logic [24:0]  i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [7:0] channel_index, [39:8] mean_value, [71:40] variance_value,
    // [103:72] bias_value, [135:104] sample
    input  wire logic [135:0] s_axis_tdata,
    input  wire logic         s_axis_tuser, // action
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [31:0] normalized, [39:32] channel_of_value, [40] saturated, pad
    output logic [47:0]       m_axis_tdata,
    output logic              m_axis_tlast  // plane_end
);
    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_fire;
    logic [ChanW-1:0] w_chan;
    logic [DataW-1:0] w_res;
    logic       w_sat;

    assign o_cfg_ready = 1'b1;
    assign w_fire = s_axis_tvalid && s_axis_tready;

    bni_ctrl #(.MAX_CHANNELS(MAX_CHANNELS)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_cfg_we(i_cfg_valid), .i_cfg_idx(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_fire(w_fire), .i_in_sample(s_axis_tuser == ActSample),
        .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_chan(w_chan), .o_last(m_axis_tlast),
        .o_cmd(w_cmd), .i_status(w_status));

    bni_datapath #(.MAX_CHANNELS(MAX_CHANNELS)) u_dp (
        .i_clk, .i_cmd(w_cmd), .o_status(w_status),
        .i_load_we(w_fire && (s_axis_tuser == ActLoad)),
        .i_load_idx(s_axis_tdata[7:0]),
        .i_mean(s_axis_tdata[39:8]), .i_var(s_axis_tdata[71:40]),
        .i_bias(s_axis_tdata[103:72]), .i_sample(s_axis_tdata[135:104]),
        .i_chan(w_chan), .o_result(w_res), .o_sat(w_sat));

    assign m_axis_tdata = {7'd0, w_sat, w_chan, w_res};
endmodule
`default_nettype wire

FILE: tb/sv/tb_batch_norm_inference.sv
`timescale 1ns / 1ps
module tb_batch_norm_inference;
    import bni_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic         i_cfg_index;
    logic [24:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // [7:0] channel_index, [39:8] mean_value, [71:40] variance_value,
    // [103:72] bias_value, [135:104] sample
    logic [135:0] s_axis_tdata;
    logic         s_axis_tuser;  // action
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // [31:0] normalized, [39:32] channel_of_value, [40] saturated, pad
    logic [47:0]  m_axis_tdata;
    logic         m_axis_tlast;  // plane_end

    batch_norm_inference dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // one expected output beat
    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  chan;
        logic        last;
        logic        sat;
    } t_norm;

    // one input beat (directed table row)
    typedef struct {
        logic        act;
        logic [7:0]  chan;
        logic [31:0] mean;
        logic [31:0] vari;
        logic [31:0] bias;
        logic [31:0] samp;
        logic        has_fixed;  // row carries a typed-in expected result
        t_norm       fixed;
    } t_beat;

    localparam int unsigned CycleLimit  = 20000;
    localparam int unsigned DrainCycles = 200;
    localparam int unsigned RandItems   = 728;

    // predictor state
    logic [31:0] mean_mem [256];
    logic [31:0] var_mem  [256];
    logic [31:0] bias_mem [256];
    logic        loaded   [256];
    logic [7:0]  cur_chan;
    logic [23:0] cur_spat;
    logic [8:0]  cfg_chans;
    logic [24:0] cfg_spat;

    t_norm  pending_q[$];
    t_norm  fixed_q[$];       // typed-in expectations from the table
    logic   fixed_flag_q[$];  // per expected beat: is a typed-in value attached
    int     errors;
    int     n_loads, n_samples, n_results, n_sat;
    int     idle_cycles;
    logic   stall_long;
    logic   src_burst;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] isqrt48(input logic [63:0] v);
        logic [63:0] res, b, x;
        res = 0; b = 64'd1 << 46; x = v;
        while (b != 0) begin
            if (x >= res + b) begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] clamp32(input logic signed [63:0] v, inout logic hit);
        if (v > 64'sh7fffffff) begin
            hit = 1'b1; return 64'sh7fffffff;
        end
        if (v < -64'sh80000000) begin
            hit = 1'b1; return -64'sh80000000;
        end
        return v;
    endfunction

    // normalize one sample for the current channel and step the plane counters
    function automatic t_norm normalize_sample(input logic [31:0] samp);
        t_norm r;
        logic signed [63:0] diff, quot, sum;
        logic [63:0] mag, den, q;
        logic        sat;
        int unsigned nch, nsp;
        logic        last;
        logic [7:0]  ch;
        ch   = cur_chan;
        sat  = 1'b0;
        diff = $signed({{32{samp[31]}}, samp})
             - $signed({{32{mean_mem[ch][31]}}, mean_mem[ch]});
        den  = isqrt48({16'd0, var_mem[ch], 16'd0}) + 64'd1;
        mag  = (diff < 0 ? -diff : diff) << 16;
        q    = mag / den;
        quot = diff < 0 ? -$signed(q) : $signed(q);
        quot = clamp32(quot, sat);
        sum  = clamp32(quot + $signed({{32{bias_mem[ch][31]}}, bias_mem[ch]}), sat);
        nch  = cfg_chans == 0 ? 1 : (cfg_chans > 256 ? 256 : cfg_chans);
        nsp  = cfg_spat == 0 ? 1 : (cfg_spat > SpatialLimit ? SpatialLimit : cfg_spat);
        last = (cur_spat + 1 >= nsp);
        if (last) begin
            cur_spat = 0;
            cur_chan = (cur_chan + 1 >= nch) ? 8'd0 : cur_chan + 8'd1;
        end else begin
            cur_spat = cur_spat + 24'd1;
        end
        r.value = sum[31:0];
        r.chan  = ch;
        r.last  = last;
        r.sat   = sat;
        return r;
    endfunction

    // drive one input beat and wait for acceptance; valid stays up for
    // a back-to-back beat and drops only before a gap or a drain
    task automatic send_beat(input t_beat b);
        t_norm exp_r;
        int    gap;
        if (!src_burst && $urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= b.act;
        s_axis_tdata  <= {b.samp, b.bias, b.vari, b.mean, b.chan};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (b.act == ActLoad) begin
            mean_mem[b.chan] = b.mean;
            var_mem[b.chan]  = b.vari;
            bias_mem[b.chan] = b.bias;
            loaded[b.chan]   = 1'b1;
            n_loads++;
        end else begin
            exp_r = normalize_sample(b.samp);
            pending_q.push_back(exp_r);
            fixed_flag_q.push_back(b.has_fixed);
            if (b.has_fixed) fixed_q.push_back(b.fixed);
            n_samples++;
        end
    endtask

    // valid is left up; the caller drops it after the last write
    task automatic write_reg(input logic idx, input logic [24:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == RegChannelCount) cfg_chans = val[8:0];
        else cfg_spat = val;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    function automatic t_beat load_beat(input logic [7:0] c, input logic [31:0] m,
                                        input logic [31:0] v, input logic [31:0] b);
        t_beat x;
        x = '{act: ActLoad, chan: c, mean: m, vari: v, bias: b, samp: $urandom,
              has_fixed: 1'b0, fixed: '0};
        return x;
    endfunction

    function automatic t_beat sample_beat(input logic [31:0] s);
        t_beat x;
        x = '{act: ActSample, chan: $urandom, mean: $urandom, vari: $urandom,
              bias: $urandom, samp: s, has_fixed: 1'b0, fixed: '0};
        return x;
    endfunction

    function automatic t_beat fixed_beat(input logic [31:0] s, input t_norm r);
        t_beat x;
        x = sample_beat(s);
        x.has_fixed = 1'b1;
        x.fixed = r;
        return x;
    endfunction

    // output checker: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_norm e, f;
        logic  hasf;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
                errors++;
            end else begin
                e = pending_q.pop_front();
                hasf = fixed_flag_q.pop_front();
                if (hasf) begin
                    f = fixed_q.pop_front();
                    if (f != e) begin
                        $display("%0t: table row disagrees, exp %h pred %h", $time, f, e);
                        errors++;
                    end
                end
                if (e.sat) n_sat++;
                if (m_axis_tdata[31:0] !== e.value) begin
                    $display("%0t: normalized exp %h got %h", $time, e.value,
                             m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[39:32] !== e.chan) begin
                    $display("%0t: channel exp %0d got %0d", $time, e.chan,
                             m_axis_tdata[39:32]);
                    errors++;
                end
                if (m_axis_tdata[40] !== e.sat) begin
                    $display("%0t: saturated exp %b got %b", $time, e.sat, m_axis_tdata[40]);
                    errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $display("%0t: plane_end exp %b got %b", $time, e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off to back up the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_long) begin
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < 8) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        stall_long = 1'b0;
        wait (n_samples >= 400);
        @(posedge i_clk);
        stall_long <= 1'b1;
        repeat (600) @(posedge i_clk);
        stall_long <= 1'b0;
    end

    // watchdog: cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_beat dir [$];
        int    k, n;
        logic [7:0] c;
        logic [31:0] m;
        logic [31:0] vsel;

        errors = 0; n_loads = 0; n_samples = 0; n_results = 0; n_sat = 0;
        idle_cycles = 0; src_burst = 1'b0;
        cur_chan = 0; cur_spat = 0; cfg_chans = 9'd1; cfg_spat = 25'd1;
        foreach (loaded[i]) loaded[i] = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = RegChannelCount; i_cfg_data = '0;
        s_axis_tvalid = 1'b0; s_axis_tuser = ActLoad; s_axis_tdata = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset settings: one channel, one sample per plane
        dir.push_back(load_beat(8'd0, 32'h0, 32'h0, 32'h0));
        // zero variance: divisor is one LSB, so quotient = diff << 16
        dir.push_back(fixed_beat(32'h0, '{32'h0, 8'd0, 1'b1, 1'b0}));
        dir.push_back(fixed_beat(32'h1, '{32'h00010000, 8'd0, 1'b1, 1'b0}));
        dir.push_back(fixed_beat(32'hffffffff, '{32'hffff0000, 8'd0, 1'b1, 1'b0}));
        dir.push_back(fixed_beat(32'h7fffffff, '{32'h7fffffff, 8'd0, 1'b1, 1'b1}));
        dir.push_back(fixed_beat(32'h80000000, '{32'h80000000, 8'd0, 1'b1, 1'b1}));
        // extremes of mean, variance and bias
        dir.push_back(load_beat(8'd0, 32'h80000000, 32'hffffffff, 32'h7fffffff));
        dir.push_back(sample_beat(32'h7fffffff));
        dir.push_back(sample_beat(32'h80000000));
        dir.push_back(load_beat(8'd0, 32'h7fffffff, 32'h00010000, 32'h80000000));
        dir.push_back(sample_beat(32'h80000000));
        dir.push_back(sample_beat(32'h7fffffff));
        // top channel index, and a channel above channel_count (never read)
        dir.push_back(load_beat(8'd255, 32'h00010000, 32'h00040000, 32'hffff0000));
        dir.push_back(load_beat(8'd1, 32'hffff0000, 32'h00000001, 32'h00008000));
        dir.push_back(load_beat(8'd0, 32'h0, 32'h00010000, 32'h00010000));
        // variance 1.0 -> root 1.0 (+1 LSB): sample 2.0 gives about 3.0
        dir.push_back(sample_beat(32'h00020000));
        dir.push_back(sample_beat(32'hfffe0000));
        foreach (dir[i]) send_beat(dir[i]);
        drain_results();

        // several settings, extremes included; load every channel in use first
        for (int ph = 0; ph < 7; ph++) begin
            logic [8:0]  nch;
            logic [24:0] nsp;
            case (ph)
                0: begin nch = 9'd256; nsp = 25'd1;  end
                1: begin nch = 9'd4;   nsp = 25'd16777216; end
                2: begin nch = 9'd0;   nsp = 25'd0;  end
                3: begin nch = 9'd300; nsp = 25'd3;  end
                4: begin nch = 9'd3;   nsp = 25'd5;  end
                5: begin nch = 9'd1;   nsp = 25'h1ffffff; end
                default: begin nch = 9'd8; nsp = 25'd2; end
            endcase
            src_burst = (ph == 4);
            write_reg(RegChannelCount, {16'd0, nch});
            write_reg(RegSpatialCount, nsp);
            i_cfg_valid <= 1'b0;
            // counters may sit beyond the new limits; every channel must be loaded
            n = (nch == 0) ? 1 : (nch > 256 ? 256 : nch);
            for (int ci = 0; ci < 256; ci++) begin
                if (!loaded[ci] || ci < n || $urandom_range(0, 15) == 0) begin
                    vsel = ($urandom_range(0, 3) == 0) ? $urandom
                         : ($urandom_range(0, 1) ? $urandom_range(0, 32'h000fffff)
                                                 : $urandom_range(0, 255));
                    send_beat(load_beat(ci[7:0], $urandom, vsel, $urandom));
                end
            end
            for (k = 0; k < RandItems / 7; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    c = $urandom_range(0, 255);
                    vsel = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 65535);
                    send_beat(load_beat(c, $urandom, vsel, $urandom));
                end else begin
                    m = mean_mem[cur_chan];
                    case ($urandom_range(0, 3))
                        0: send_beat(sample_beat($urandom));
                        1: send_beat(sample_beat(m + $urandom_range(0, 65535) - 32768));
                        2: send_beat(sample_beat($urandom_range(0, 1) ? 32'h7fffffff
                                                                     : 32'h80000000));
                        default: send_beat(sample_beat(m + ($urandom & 32'h00ffffff)));
                    endcase
                end
            end
            drain_results();
        end

        $display("Run covered %0d loads and %0d samples (%0d results, %0d saturated)",
                 n_loads, n_samples, n_results, n_sat);
        $display("over seven channel/plane settings, with long output stalls.");
        if (errors == 0 && pending_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

FILE: files.f
rtl/bni_pkg.sv
rtl/bni_ram.sv
rtl/bni_datapath.sv
rtl/bni_ctrl.sv
rtl/batch_norm_inference.sv
tb/sv/tb_batch_norm_inference.sv
